### src/pg_pkg.sv
// Package for the wavetable page selector: field widths, register and mode codes,
// ratio constants and the structs that pass between the pipeline modules.
// No dependencies.
package pg_pkg;

    localparam int PG_FREQ_W    = 24;
    localparam int PG_MODE_W    = 3;
    localparam int PG_COUNT_W   = 5;
    localparam int PG_INDEX_W   = 4;
    localparam int PG_CFG_IDX_W = 2;

    localparam int PG_MAX_PAGES = 16;
    localparam int PG_EQ_TAPS   = PG_MAX_PAGES - 1;
    localparam int PG_EQ_W      = $clog2(PG_EQ_TAPS + 1);
    localparam int PG_EQ_PROD_W = PG_FREQ_W + PG_EQ_W;

    localparam int PG_OCT_LIMIT = 24;
    localparam int PG_OCT_W     = $clog2(PG_OCT_LIMIT + 1);
    localparam int PG_OCT_CMP_W = PG_FREQ_W + PG_OCT_LIMIT;

    localparam int PG_RATIO_FRAC = 16;
    localparam int PG_RATIO_W    = 17;
    localparam int PG_PROD_W     = PG_FREQ_W + PG_RATIO_W;
    localparam int PG_FIX_W      = PG_FREQ_W + PG_RATIO_FRAC;
    localparam int PG_WIDE_W     = PG_PROD_W + PG_OCT_LIMIT;
    localparam int PG_RAW_W      = 7;

    // Register indexes of the configuration port.
    localparam logic [PG_CFG_IDX_W-1:0] PG_REG_BASE  = 2'd0;
    localparam logic [PG_CFG_IDX_W-1:0] PG_REG_MODE  = 2'd1;
    localparam logic [PG_CFG_IDX_W-1:0] PG_REG_COUNT = 2'd2;

    // Page spacing modes.
    localparam logic [PG_MODE_W-1:0] PG_MODE_EQUAL   = 3'd0;
    localparam logic [PG_MODE_W-1:0] PG_MODE_FULL    = 3'd1;
    localparam logic [PG_MODE_W-1:0] PG_MODE_QUARTER = 3'd2;
    localparam logic [PG_MODE_W-1:0] PG_MODE_THIRD   = 3'd3;
    localparam logic [PG_MODE_W-1:0] PG_MODE_HALF    = 3'd4;
    localparam logic [PG_MODE_W-1:0] PG_MODE_OCTAVE  = 3'd5;
    localparam logic [PG_MODE_W-1:0] PG_MODE_DOUBLE  = 3'd6;
    localparam logic [PG_MODE_W-1:0] PG_MODE_UNUSED  = 3'd7;

    localparam logic [PG_FREQ_W-1:0]  PG_BASE_RESET  = 24'd25600;
    localparam logic [PG_MODE_W-1:0]  PG_MODE_RESET  = PG_MODE_OCTAVE;
    localparam logic [PG_COUNT_W-1:0] PG_COUNT_RESET = 5'd1;

    // Q1.16 values of 2^(1/4), 2^(2/4), 2^(3/4), 2^(1/3), 2^(2/3), rounded to nearest.
    localparam logic [PG_RATIO_W-1:0] PG_RATIO_Q1 = 17'd77936;
    localparam logic [PG_RATIO_W-1:0] PG_RATIO_Q2 = 17'd92682;
    localparam logic [PG_RATIO_W-1:0] PG_RATIO_Q3 = 17'd110218;
    localparam logic [PG_RATIO_W-1:0] PG_RATIO_T1 = 17'd82570;
    localparam logic [PG_RATIO_W-1:0] PG_RATIO_T2 = 17'd104032;

    typedef struct packed {
        logic [PG_FREQ_W-1:0]  base;
        logic [PG_MODE_W-1:0]  mode;
        logic [PG_COUNT_W-1:0] lim;
        logic                  empty;
        logic                  single;
        logic [PG_PROD_W-1:0]  prod_q1;
        logic [PG_PROD_W-1:0]  prod_q2;
        logic [PG_PROD_W-1:0]  prod_q3;
        logic [PG_PROD_W-1:0]  prod_t1;
        logic [PG_PROD_W-1:0]  prod_t2;
    } t_cfg;

    typedef struct packed {
        logic [PG_FREQ_W-1:0] freq;
        logic [PG_OCT_W-1:0]  oct;
        logic [PG_EQ_W-1:0]   eq_idx;
        logic                 zero_page;
        logic                 last_page;
    } t_mid;

endpackage

### src/wavetable_page_select.sv
// Top level of the wavetable page selector: configuration registers and the
// four-stage lookup pipeline. Depends on pg_pkg, pg_cfg, pg_front and pg_back.
//
// Usage:
// Base frequency, spacing mode and page count are written through the plain
// write port (i_cfg_wr_en, i_cfg_index, i_cfg_data) while no item is in flight.
// Each input item carries one requested frequency on i_frequency and is taken
// when i_in_valid is high and o_in_stall is low. Each item yields one result
// item, o_page_index and o_not_found, taken when o_out_valid is high and
// i_out_stall is low.
// The result reaches the output register through four register stages: input register,
// threshold compares, count encoding, fractional-octave compare with mode selection
// and clamping. One item is accepted every cycle while o_in_stall is low.
// When the receiver stalls, the output register holds its item and each
// earlier stage keeps filling until it holds a valid item; o_in_stall rises
// only when all four stages are full.
// Reset clears every stage valid bit and returns the registers to base 100 Hz,
// octave spacing and a single page.
module wavetable_page_select import pg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [PG_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PG_FREQ_W-1:0]    i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [PG_FREQ_W-1:0]    i_frequency,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [PG_INDEX_W-1:0]   o_page_index,
    output logic                    o_not_found
);

    t_cfg w_cfg;
    t_mid w_mid;
    logic w_mid_valid;
    logic w_back_ready;

    pg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_frequency (i_frequency),
        .o_valid     (w_mid_valid),
        .i_ready     (w_back_ready),
        .o_mid       (w_mid)
    );

    pg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (w_mid_valid),
        .o_ready      (w_back_ready),
        .i_mid        (w_mid),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_page_index (o_page_index),
        .o_not_found  (o_not_found)
    );

endmodule

### src/pg_cfg.sv
// Configuration registers of the page selector and the values derived from them:
// clamped page limit and the base frequency scaled by each fractional octave ratio.
// Depends on pg_pkg.
module pg_cfg import pg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [PG_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PG_FREQ_W-1:0]    i_cfg_data,
    output t_cfg                    o_cfg
);

    logic [PG_FREQ_W-1:0]  r_base;
    logic [PG_MODE_W-1:0]  r_mode;
    logic [PG_COUNT_W-1:0] r_count;
    logic [PG_PROD_W-1:0]  r_prod_q1;
    logic [PG_PROD_W-1:0]  r_prod_q2;
    logic [PG_PROD_W-1:0]  r_prod_q3;
    logic [PG_PROD_W-1:0]  r_prod_t1;
    logic [PG_PROD_W-1:0]  r_prod_t2;
    logic [PG_COUNT_W-1:0] w_pages;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= PG_BASE_RESET;
            r_mode  <= PG_MODE_RESET;
            r_count <= PG_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                PG_REG_BASE:  r_base  <= i_cfg_data;
                PG_REG_MODE:  r_mode  <= i_cfg_data[PG_MODE_W-1:0];
                PG_REG_COUNT: r_count <= i_cfg_data[PG_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Constant products follow the base register in the next cycle; an item reaches
    // the stage that reads them well after that.
    always_ff @(posedge i_clk) begin
        r_prod_q1 <= PG_PROD_W'(r_base) * PG_PROD_W'(PG_RATIO_Q1);
        r_prod_q2 <= PG_PROD_W'(r_base) * PG_PROD_W'(PG_RATIO_Q2);
        r_prod_q3 <= PG_PROD_W'(r_base) * PG_PROD_W'(PG_RATIO_Q3);
        r_prod_t1 <= PG_PROD_W'(r_base) * PG_PROD_W'(PG_RATIO_T1);
        r_prod_t2 <= PG_PROD_W'(r_base) * PG_PROD_W'(PG_RATIO_T2);
    end

    assign w_pages = (r_count > PG_COUNT_W'(PG_MAX_PAGES)) ? PG_COUNT_W'(PG_MAX_PAGES) : r_count;

    always_comb begin
        o_cfg         = '0;
        o_cfg.base    = r_base;
        o_cfg.mode    = r_mode;
        o_cfg.lim     = w_pages - PG_COUNT_W'(1);
        o_cfg.empty   = (w_pages == '0);
        o_cfg.single  = (w_pages == PG_COUNT_W'(1));
        o_cfg.prod_q1 = r_prod_q1;
        o_cfg.prod_q2 = r_prod_q2;
        o_cfg.prod_q3 = r_prod_q3;
        o_cfg.prod_t1 = r_prod_t1;
        o_cfg.prod_t2 = r_prod_t2;
    end

endmodule

### src/pg_front.sv
// Front of the page selector pipeline: input register, parallel compares of the
// frequency against base multiples and octaves, and encoding of the counts.
// Depends on pg_pkg.
module pg_front import pg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PG_FREQ_W-1:0] i_frequency,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_mid                 o_mid
);

    logic                    r_a_valid;
    logic [PG_FREQ_W-1:0]    r_a_freq;
    logic                    r_b_valid;
    logic [PG_FREQ_W-1:0]    r_b_freq;
    logic [PG_OCT_LIMIT-1:0] r_b_oct_th;
    logic [PG_EQ_TAPS-1:0]   r_b_eq_th;
    logic                    r_b_zero;
    logic                    r_b_last;
    logic                    r_c_valid;
    t_mid                    r_c_mid;

    logic                    w_a_ready;
    logic                    w_b_ready;
    logic                    w_c_ready;
    logic [PG_OCT_LIMIT-1:0] w_oct_th;
    logic [PG_EQ_TAPS-1:0]   w_eq_th;
    logic                    w_zero;
    logic [PG_OCT_LIMIT-1:0] w_oct_hot;
    logic [PG_EQ_TAPS-1:0]   w_eq_hot;
    t_mid                    w_mid;

    assign w_c_ready = !r_c_valid || i_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_stall   = !w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (w_c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Bit k-1 of each thermometer is set when base*k (equal) or base*2^k (octave)
    // does not exceed the frequency; both fill from the bottom up.
    always_comb begin
        for (int k = 1; k <= PG_OCT_LIMIT; k++) begin
            w_oct_th[k-1] = ((PG_OCT_CMP_W'(i_cfg.base) << k) <= PG_OCT_CMP_W'(r_a_freq));
        end
        for (int k = 1; k <= PG_EQ_TAPS; k++) begin
            w_eq_th[k-1] = ((PG_EQ_PROD_W'(i_cfg.base) * PG_EQ_PROD_W'(k))
                           <= PG_EQ_PROD_W'(r_a_freq));
        end
    end

    assign w_zero = i_cfg.single || (r_a_freq == '0) || (r_a_freq < i_cfg.base)
                 || (i_cfg.mode == PG_MODE_FULL) || (i_cfg.mode == PG_MODE_UNUSED);

    always_ff @(posedge i_clk) begin
        if (w_b_ready) begin
            r_b_freq   <= r_a_freq;
            r_b_oct_th <= w_oct_th;
            r_b_eq_th  <= w_eq_th;
            r_b_zero   <= w_zero;
            r_b_last   <= (i_cfg.base == '0);
        end
    end

    if (1) begin : g_a_load
        always_ff @(posedge i_clk) begin
            if (w_a_ready) begin
                r_a_freq <= i_frequency;
            end
        end
    end

    // The top set bit of a thermometer gives its count.
    assign w_oct_hot = r_b_oct_th & ~(r_b_oct_th >> 1);
    assign w_eq_hot  = r_b_eq_th & ~(r_b_eq_th >> 1);

    always_comb begin
        w_mid           = '0;
        w_mid.freq      = r_b_freq;
        w_mid.zero_page = r_b_zero;
        w_mid.last_page = r_b_last;
        for (int k = 0; k < PG_OCT_LIMIT; k++) begin
            w_mid.oct = w_mid.oct | (w_oct_hot[k] ? PG_OCT_W'(k + 1) : '0);
        end
        for (int k = 0; k < PG_EQ_TAPS; k++) begin
            w_mid.eq_idx = w_mid.eq_idx | (w_eq_hot[k] ? PG_EQ_W'(k + 1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready) begin
            r_c_mid <= w_mid;
        end
    end

    assign o_valid = r_c_valid;
    assign o_mid   = r_c_mid;

endmodule

### src/pg_back.sv
// Back of the page selector pipeline: fractional octave compares, index per
// spacing mode, clamping and the output register.
// Depends on pg_pkg.
module pg_back import pg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_mid                  i_mid,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PG_INDEX_W-1:0] o_page_index,
    output logic                  o_not_found
);

    logic                  r_d_valid;
    logic [PG_INDEX_W-1:0] r_page_index;
    logic                  r_not_found;

    logic [PG_PROD_W-1:0]  w_prod [3];
    logic [2:0]            w_use;
    logic [2:0]            w_pass;
    logic [PG_FIX_W-1:0]   w_fix;
    logic [1:0]            w_sub;
    logic [PG_RAW_W-1:0]   w_oct;
    logic [PG_RAW_W-1:0]   w_raw;
    logic [PG_RAW_W-1:0]   w_lim;
    logic [PG_RAW_W-1:0]   w_sel;

    assign o_ready = !r_d_valid || !i_stall;

    always_comb begin
        w_prod[0] = i_cfg.prod_q1;
        w_prod[1] = i_cfg.prod_q2;
        w_prod[2] = i_cfg.prod_q3;
        w_use     = 3'b111;
        case (i_cfg.mode)
            PG_MODE_THIRD: begin
                w_prod[0] = i_cfg.prod_t1;
                w_prod[1] = i_cfg.prod_t2;
                w_use     = 3'b011;
            end
            PG_MODE_HALF: begin
                w_prod[0] = i_cfg.prod_q2;
                w_use     = 3'b001;
            end
            default: ;
        endcase
    end

    // The threshold for step j inside an octave is (base * ratio_j) << octave.
    assign w_fix = {i_mid.freq, {PG_RATIO_FRAC{1'b0}}};

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_pass[j] = w_use[j]
                     && ((PG_WIDE_W'(w_prod[j]) << i_mid.oct) <= PG_WIDE_W'(w_fix));
        end
    end

    assign w_sub = {1'b0, w_pass[0]} + {1'b0, w_pass[1]} + {1'b0, w_pass[2]};
    assign w_oct = PG_RAW_W'(i_mid.oct);
    assign w_lim = PG_RAW_W'(i_cfg.lim);

    always_comb begin
        unique case (i_cfg.mode)
            PG_MODE_EQUAL:   w_raw = PG_RAW_W'(i_mid.eq_idx);
            PG_MODE_QUARTER: w_raw = (w_oct << 2) + PG_RAW_W'(w_sub);
            PG_MODE_THIRD:   w_raw = (w_oct << 1) + w_oct + PG_RAW_W'(w_sub);
            PG_MODE_HALF:    w_raw = (w_oct << 1) + PG_RAW_W'(w_sub);
            PG_MODE_OCTAVE:  w_raw = w_oct;
            PG_MODE_DOUBLE:  w_raw = w_oct >> 1;
            default:         w_raw = '0;
        endcase
    end

    always_comb begin
        if (i_cfg.empty || i_mid.zero_page) begin
            w_sel = '0;
        end else if (i_mid.last_page || (w_raw > w_lim)) begin
            w_sel = w_lim;
        end else begin
            w_sel = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (o_ready) begin
            r_d_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_page_index <= w_sel[PG_INDEX_W-1:0];
            r_not_found  <= i_cfg.empty;
        end
    end

    assign o_valid      = r_d_valid;
    assign o_page_index = r_page_index;
    assign o_not_found  = r_not_found;

    a_index_within_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid && !r_not_found |-> PG_COUNT_W'(r_page_index) <= i_cfg.lim)
        else $error("page index above page count limit");

    a_empty_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid && i_cfg.empty |-> r_not_found && (r_page_index == '0))
        else $error("empty table did not raise not_found with page zero");

    a_zero_page_loaded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mid.zero_page |=> r_d_valid && (r_page_index == '0))
        else $error("item that selects page zero left a nonzero index");

endmodule
